@@ src/lbc_pkg.sv @@
// Shared types, constants and saturating helpers for the D2Q9 BGK collision block.
package lbc_pkg;

    localparam int N_DIRS     = 9;
    localparam int DIV_STAGES = 33;                 // quotient bits 32..0
    localparam int DIV_LAT    = DIV_STAGES + 2;     // setup + bit stages + final
    localparam int LANE_LAT   = 9;
    localparam int PIPE_LAT   = 1 + DIV_LAT + LANE_LAT;
    localparam logic [30:0] RELAX_RATE_RST = 31'd536458864;

    localparam int DIR_X [N_DIRS] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int DIR_Y [N_DIRS] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    localparam int DIR_W [N_DIRS] = '{0, 1, 1, 1, 1, 2, 2, 2, 2};

    typedef struct packed {
        logic signed [31:0] f_rest;
        logic signed [31:0] f_east;
        logic signed [31:0] f_north;
        logic signed [31:0] f_west;
        logic signed [31:0] f_south;
        logic signed [31:0] f_northeast;
        logic signed [31:0] f_northwest;
        logic signed [31:0] f_southwest;
        logic signed [31:0] f_southeast;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] post_rest;
        logic signed [31:0] post_east;
        logic signed [31:0] post_north;
        logic signed [31:0] post_west;
        logic signed [31:0] post_south;
        logic signed [31:0] post_northeast;
        logic signed [31:0] post_northwest;
        logic signed [31:0] post_southwest;
        logic signed [31:0] post_southeast;
        logic signed [31:0] density;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
    } out_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Floor shift of a product, then clamp
    function automatic logic signed [31:0] qsh(input logic signed [63:0] p,
                                               input int unsigned sh);
        logic signed [63:0] s;
        s = p >>> sh;
        return sat32(s);
    endfunction

endpackage

@@ src/lbc_if.sv @@
// Valid/ready channel interfaces for cell input and collision result.
interface lbc_in_if;
    logic               valid;
    logic               ready;
    lbc_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lbc_out_if;
    logic               valid;
    logic               ready;
    lbc_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/lbc_div.sv @@
// Pipelined restoring divider: momentum / density in fixed point, saturated.
module lbc_div #(
    parameter int FRAC_BITS = 28
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] m,
    input  logic signed [31:0] d,
    output logic signed [31:0] q
);
    localparam int NW = 32 + FRAC_BITS;
    localparam int S  = lbc_pkg::DIV_STAGES;

    logic [31:0]  rem_reg  [S+1];
    logic [S-1:0] low_reg  [S+1];
    logic [S-1:0] quo_reg  [S+1];
    logic [31:0]  b_reg    [S+1];
    logic         neg_reg  [S+1];
    logic         ovf_reg  [S+1];
    logic         zero_reg [S+1];

    logic [32:0]  a;
    logic [NW-1:0] n;
    logic [NW-1:0] hi;
    logic signed [31:0] q_next;
    logic signed [31:0] q_reg;
    logic [S-1:0] lim;
    logic [S-1:0] mag;

    always_comb
    begin
        a  = (m < 0) ? (33'd0 - {m[31], m}) : {1'b0, m};
        n  = NW'(a) << FRAC_BITS;
        hi = n >> S;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= hi[31:0];
            low_reg[0]  <= n[S-1:0];
            quo_reg[0]  <= '0;
            b_reg[0]    <= d;
            neg_reg[0]  <= m < 0;
            ovf_reg[0]  <= hi >= NW'(d[30:0]);
            zero_reg[0] <= d <= 0;
        end
    end

    for (genvar i = 0; i < S; i++)
    begin : g_stage
        logic [32:0] t;
        logic [32:0] t_sub;
        logic        take;
        always_comb
        begin
            t     = {rem_reg[i], low_reg[i][S-1]};
            take  = t >= {1'b0, b_reg[i]};
            t_sub = t - {1'b0, b_reg[i]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= take ? t_sub[31:0] : t[31:0];
                low_reg[i+1]  <= {low_reg[i][S-2:0], 1'b0};
                quo_reg[i+1]  <= {quo_reg[i][S-2:0], take};
                b_reg[i+1]    <= b_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                ovf_reg[i+1]  <= ovf_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    always_comb
    begin
        lim = neg_reg[S] ? 33'h080000000 : 33'h07fffffff;
        mag = (ovf_reg[S] || quo_reg[S] > lim) ? lim : quo_reg[S];
        if (zero_reg[S])
            q_next = '0;
        else if (neg_reg[S])
            q_next = 32'sd0 - $signed(mag[31:0]);
        else
            q_next = $signed(mag[31:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

@@ src/lbc_lane.sv @@
// One direction lane: equilibrium from velocity and density, then BGK relaxation.
module lbc_lane #(
    parameter int FRAC_BITS = 28,
    parameter int EX        = 0,
    parameter int EY        = 0,
    parameter int WSEL      = 0
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] ux,
    input  logic signed [31:0] uy,
    input  logic signed [31:0] uu,     // lags ux/uy by the sqx_reg and uu_reg registers
    input  logic signed [31:0] rho,
    input  logic signed [31:0] f,
    input  logic [30:0]        omega,
    output logic signed [31:0] post
);
    localparam longint VMAX  = 64'sd2147483647;
    localparam longint WNUM  = (WSEL == 0) ? 4 : 1;
    localparam longint WDEN  = (WSEL == 2) ? 36 : 9;
    localparam longint W_RAW = ((WNUM <<< FRAC_BITS) + WDEN / 2) / WDEN;
    localparam longint O_RAW = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] WGT = 32'((W_RAW > VMAX) ? VMAX : W_RAW);
    localparam logic signed [31:0] ONE = 32'((O_RAW > VMAX) ? VMAX : O_RAW);

    logic signed [63:0] sx, sy, eu_sum;
    logic signed [31:0] eu1_reg, t1_1_reg, t1_2_reg, t1_3_reg;
    logic signed [63:0] eusq2_reg;
    logic signed [31:0] t2_3_reg, t3_3_reg, g4_reg, diff7_reg, post9_reg;
    logic signed [63:0] gw5_reg, p6_reg, p8_reg;
    logic signed [31:0] f_reg   [8];
    logic signed [31:0] rho_reg [5];
    logic signed [31:0] eq, s12, si, g, feq;

    always_comb
    begin
        sx     = (EX > 0) ? 64'(ux) : (EX < 0) ? -64'(ux) : 64'sd0;
        sy     = (EY > 0) ? 64'(uy) : (EY < 0) ? -64'(uy) : 64'sd0;
        eu_sum = sx + sy;
        eq     = lbc_pkg::qsh(eusq2_reg, FRAC_BITS);
        s12    = lbc_pkg::sat32(64'(t1_3_reg) + 64'(t2_3_reg));
        si     = lbc_pkg::sat32(64'(s12) - 64'(t3_3_reg));
        g      = lbc_pkg::sat32(64'(ONE) + 64'(si));
        feq    = lbc_pkg::qsh(p6_reg, FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eu1_reg   <= lbc_pkg::sat32(eu_sum);
            t1_1_reg  <= lbc_pkg::sat32(64'sd3 * 64'(lbc_pkg::sat32(eu_sum)));
            eusq2_reg <= 64'(eu1_reg) * 64'(eu1_reg);
            t1_2_reg  <= t1_1_reg;
            t2_3_reg  <= lbc_pkg::sat32((64'sd9 * 64'(eq)) >>> 1);
            t3_3_reg  <= lbc_pkg::sat32((64'sd3 * 64'(uu)) >>> 1);
            t1_3_reg  <= t1_2_reg;
            g4_reg    <= g;
            gw5_reg   <= 64'(g4_reg) * 64'(WGT);
            p6_reg    <= 64'(lbc_pkg::qsh(gw5_reg, FRAC_BITS)) * 64'(rho_reg[4]);
            diff7_reg <= lbc_pkg::sat32(64'(f_reg[5]) - 64'(feq));
            p8_reg    <= 64'(diff7_reg) * $signed({33'd0, omega});
            post9_reg <= lbc_pkg::sat32(64'(f_reg[7])
                         - 64'(lbc_pkg::qsh(p8_reg, FRAC_BITS)));
            f_reg[0]   <= f;
            rho_reg[0] <= rho;
            for (int i = 1; i < 8; i++)
                f_reg[i] <= f_reg[i-1];
            for (int i = 1; i < 5; i++)
                rho_reg[i] <= rho_reg[i-1];
        end
    end

    assign post = post9_reg;

endmodule

@@ src/lattice_cell_bgk_collision.sv @@
// Top level: D2Q9 BGK collision pipeline, one lattice cell per cycle while out_ch does not stall.
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    nine distributions f_*, signed Q4.28
//  out_ch    out  valid/ready    nine post_*, density, velocity_x, velocity_y
//  cfg       in   cfg_we         cfg_wdata = relax_rate (omega), 31 bits
//
// Throughput one cell per cycle while out_ch does not stall; the path to out_ch.valid runs
// through the 33-stage quotient pipeline of the two dividers plus the 9-stage lanes.
// Reset clears the pipeline valid bits and the output valid; relax_rate returns to
// its reset value. A stall on out_ch freezes the pipeline only while its last stage
// holds a cell; bubbles keep draining so in_ch.ready stays high until then.
module lattice_cell_bgk_collision #(
    parameter int FRAC_BITS = 28
) (
    input  logic         clk,
    input  logic         rst_n,
    lbc_in_if.sink       in_ch,
    lbc_out_if.source    out_ch,
    input  logic         cfg_we,
    input  logic [30:0]  cfg_wdata
);
    localparam int ND  = lbc_pkg::N_DIRS;
    localparam int LAT = lbc_pkg::PIPE_LAT;
    localparam int DL  = lbc_pkg::DIV_LAT;
    localparam int LL  = lbc_pkg::LANE_LAT;

    logic [30:0]        omega_reg;
    logic [LAT-1:0]     v_reg;
    logic               en, last;
    logic               out_valid_reg;
    lbc_pkg::out_item_t out_data_reg;

    logic signed [31:0] fin [ND];
    logic signed [63:0] sum, mx, my;
    logic signed [31:0] f_s1_reg [ND];
    logic signed [31:0] rho_s1_reg, mx_s1_reg, my_s1_reg;
    logic signed [31:0] f_dly_reg [DL][ND];
    logic signed [31:0] rho_dly_reg [DL];
    logic signed [31:0] ux, uy;
    logic signed [63:0] sqx_reg, sqy_reg;
    logic signed [31:0] uu_reg;
    logic signed [31:0] rho_o_reg [LL];
    logic signed [31:0] ux_o_reg  [LL];
    logic signed [31:0] uy_o_reg  [LL];
    logic signed [31:0] post [ND];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            omega_reg <= lbc_pkg::RELAX_RATE_RST;
        else if (cfg_we)
            omega_reg <= cfg_wdata;
    end

    assign last         = v_reg[LAT-1];
    assign en           = !out_valid_reg || out_ch.ready || !last;
    assign in_ch.ready  = en;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
                v_reg <= {v_reg[LAT-2:0], in_ch.valid};
            if (en && last)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Moments of the incoming cell
    always_comb
    begin
        fin[0] = in_ch.data.f_rest;
        fin[1] = in_ch.data.f_east;
        fin[2] = in_ch.data.f_north;
        fin[3] = in_ch.data.f_west;
        fin[4] = in_ch.data.f_south;
        fin[5] = in_ch.data.f_northeast;
        fin[6] = in_ch.data.f_northwest;
        fin[7] = in_ch.data.f_southwest;
        fin[8] = in_ch.data.f_southeast;
        sum = '0;
        for (int k = 0; k < ND; k++)
            sum = sum + 64'(fin[k]);
        mx = 64'(fin[1]) - 64'(fin[3]) + 64'(fin[5]) - 64'(fin[6])
             - 64'(fin[7]) + 64'(fin[8]);
        my = 64'(fin[2]) - 64'(fin[4]) + 64'(fin[5]) + 64'(fin[6])
             - 64'(fin[7]) - 64'(fin[8]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_s1_reg   <= fin;
            rho_s1_reg <= lbc_pkg::sat32(sum);
            mx_s1_reg  <= lbc_pkg::sat32(mx);
            my_s1_reg  <= lbc_pkg::sat32(my);
            f_dly_reg[0]   <= f_s1_reg;
            rho_dly_reg[0] <= rho_s1_reg;
            for (int i = 1; i < DL; i++)
            begin
                f_dly_reg[i]   <= f_dly_reg[i-1];
                rho_dly_reg[i] <= rho_dly_reg[i-1];
            end
        end
    end

    lbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk (clk), .en (en), .m (mx_s1_reg), .d (rho_s1_reg), .q (ux)
    );

    lbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk (clk), .en (en), .m (my_s1_reg), .d (rho_s1_reg), .q (uy)
    );

    // Speed squared, shared by all lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= 64'(ux) * 64'(ux);
            sqy_reg <= 64'(uy) * 64'(uy);
            uu_reg  <= lbc_pkg::sat32(64'(lbc_pkg::qsh(sqx_reg, FRAC_BITS))
                       + 64'(lbc_pkg::qsh(sqy_reg, FRAC_BITS)));
            rho_o_reg[0] <= rho_dly_reg[DL-1];
            ux_o_reg[0]  <= ux;
            uy_o_reg[0]  <= uy;
            for (int i = 1; i < LL; i++)
            begin
                rho_o_reg[i] <= rho_o_reg[i-1];
                ux_o_reg[i]  <= ux_o_reg[i-1];
                uy_o_reg[i]  <= uy_o_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < ND; k++)
    begin : g_lane
        lbc_lane #(
            .FRAC_BITS (FRAC_BITS),
            .EX        (lbc_pkg::DIR_X[k]),
            .EY        (lbc_pkg::DIR_Y[k]),
            .WSEL      (lbc_pkg::DIR_W[k])
        ) u_lane (
            .clk   (clk),
            .en    (en),
            .ux    (ux),
            .uy    (uy),
            .uu    (uu_reg),
            .rho   (rho_dly_reg[DL-1]),
            .f     (f_dly_reg[DL-1][k]),
            .omega (omega_reg),
            .post  (post[k])
        );
    end

    // Merge lane results with the moments
    always_ff @(posedge clk)
    begin
        if (en && last)
        begin
            out_data_reg.post_rest      <= post[0];
            out_data_reg.post_east      <= post[1];
            out_data_reg.post_north     <= post[2];
            out_data_reg.post_west      <= post[3];
            out_data_reg.post_south     <= post[4];
            out_data_reg.post_northeast <= post[5];
            out_data_reg.post_northwest <= post[6];
            out_data_reg.post_southwest <= post[7];
            out_data_reg.post_southeast <= post[8];
            out_data_reg.density        <= rho_o_reg[LL-1];
            out_data_reg.velocity_x     <= ux_o_reg[LL-1];
            out_data_reg.velocity_y     <= uy_o_reg[LL-1];
        end
    end

    a_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.density <= 0) |->
        (out_data_reg.velocity_x == 0 && out_data_reg.velocity_y == 0))
        else $error("nonzero velocity with non-positive density");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (out_valid_reg && last))
        else $error("input stalled without a blocked result");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> v_reg[0])
        else $error("accepted cell not tracked in pipeline");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (last && en) |=> out_valid_reg)
        else $error("finished cell not presented");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the D2Q9 BGK collision block.
`timescale 1ns / 1ps

module tb_top;

    localparam int FB = 28;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam int HOLD_LONG = 300;
    localparam int N_PHASES = 5;
    localparam int ITEMS_PER_PHASE = 110;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [30:0] cfg_wdata;

    lbc_in_if  in_ch ();
    lbc_out_if out_ch ();

    lattice_cell_bgk_collision uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    lbc_pkg::in_item_t  cells_pending[$];
    lbc_pkg::out_item_t collisions_due[$];
    logic [30:0] omega_q;
    logic in_took;
    logic out_took;
    int gap_left;
    int stall_left;
    int gap_max;
    int stall_max;
    int hold_req;
    int hold_seen;
    int hold_left;
    int mismatches;

    function automatic longint sat_q(longint v);
        if (v > QMAX)
            return QMAX;
        if (v < QMIN)
            return QMIN;
        return v;
    endfunction

    function automatic longint mul_q(longint a, longint b);
        return sat_q((a * b) >>> FB);
    endfunction

    function automatic longint round_const(longint num, longint den);
        return sat_q(((num <<< FB) + den / 2) / den);
    endfunction

    // Restoring fraction division, truncated toward zero
    function automatic longint velocity_of(longint mom, longint rho);
        bit neg;
        longint unsigned a, b, q, r, lim;
        neg = mom < 0;
        a = neg ? -mom : mom;
        b = rho;
        q = a / b;
        r = a % b;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        for (int i = 0; i < FB; i++)
        begin
            if (q >= 64'h1_0000_0000)
                break;
            q = q << 1;
            r = r << 1;
            if (r >= b)
            begin
                r = r - b;
                q = q | 1;
            end
        end
        if (q > lim)
            q = lim;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic lbc_pkg::out_item_t collide_cell(lbc_pkg::in_item_t c,
                                                        logic [30:0] omega);
        longint f[lbc_pkg::N_DIRS];
        longint wt[3];
        longint sum, mx, my, rho, ux, uy, uu, one, eu, t1, t2, t3, si, g, feq, diff;
        logic [31:0] post[lbc_pkg::N_DIRS];
        lbc_pkg::out_item_t o;
        f = '{c.f_rest, c.f_east, c.f_north, c.f_west, c.f_south,
              c.f_northeast, c.f_northwest, c.f_southwest, c.f_southeast};
        sum = 0;
        mx = 0;
        my = 0;
        ux = 0;
        uy = 0;
        for (int k = 0; k < lbc_pkg::N_DIRS; k++)
        begin
            sum += f[k];
            mx += lbc_pkg::DIR_X[k] * f[k];
            my += lbc_pkg::DIR_Y[k] * f[k];
        end
        rho = sat_q(sum);
        mx = sat_q(mx);
        my = sat_q(my);
        if (rho > 0)
        begin
            ux = velocity_of(mx, rho);
            uy = velocity_of(my, rho);
        end
        wt[0] = round_const(4, 9);
        wt[1] = round_const(1, 9);
        wt[2] = round_const(1, 36);
        one = round_const(1, 1);
        uu = sat_q(mul_q(ux, ux) + mul_q(uy, uy));
        for (int k = 0; k < lbc_pkg::N_DIRS; k++)
        begin
            eu = sat_q(lbc_pkg::DIR_X[k] * ux + lbc_pkg::DIR_Y[k] * uy);
            t1 = sat_q(3 * eu);
            t2 = sat_q((9 * mul_q(eu, eu)) >>> 1);
            t3 = sat_q((3 * uu) >>> 1);
            si = sat_q(sat_q(t1 + t2) - t3);
            g = sat_q(one + si);
            feq = mul_q(mul_q(g, wt[lbc_pkg::DIR_W[k]]), rho);
            diff = sat_q(f[k] - feq);
            post[k] = 32'(sat_q(f[k] - mul_q(diff, longint'(omega))));
        end
        o = {post[0], post[1], post[2], post[3], post[4], post[5], post[6], post[7],
             post[8], rho[31:0], ux[31:0], uy[31:0]};
        return o;
    endfunction

    function automatic lbc_pkg::in_item_t random_cell();
        logic [31:0] v[lbc_pkg::N_DIRS];
        longint rho0, wv;
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < lbc_pkg::N_DIRS; k++)
        begin
            if (mode < 6)
            begin
                // near-equilibrium cell with noise
                if (k == 0)
                    rho0 = $urandom_range(1 << 24, 1 << 30);
                wv = (k == 0) ? rho0 * 4 / 9 : (k < 5) ? rho0 / 9 : rho0 / 36;
                v[k] = 32'(wv + $urandom_range(0, 1 << 25) - (1 << 24));
            end
            else if (mode < 8)
                v[k] = $urandom;
            else
                case ($urandom_range(0, 3))
                    0: v[k] = 32'h7fffffff;
                    1: v[k] = 32'h80000000;
                    2: v[k] = 0;
                    default: v[k] = $urandom;
                endcase
        end
        return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sender: hold each cell until taken, then idle a drawn gap
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && !in_took)
                ;
            else if (gap_left > 0)
            begin
                in_ch.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (cells_pending.size() > 0)
            begin
                in_ch.data <= cells_pending.pop_front();
                in_ch.valid <= 1'b1;
                gap_left <= $urandom_range(0, gap_max);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        int draw;
        if (rst_n)
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen <= hold_req;
                hold_left <= HOLD_LONG;
                out_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (out_took)
            begin
                draw = $urandom_range(0, stall_max);
                stall_left <= (draw > 0) ? draw - 1 : 0;
                out_ch.ready <= (draw == 0);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        lbc_pkg::out_item_t seen, want;
        in_took <= in_ch.valid && in_ch.ready;
        out_took <= out_ch.valid && out_ch.ready;
        if (cfg_we)
            omega_q <= cfg_wdata;
        if (rst_n && in_ch.valid && in_ch.ready)
            collisions_due.push_back(collide_cell(in_ch.data, omega_q));
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen = out_ch.data;
            if (collisions_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", seen);
            end
            else
            begin
                want = collisions_due.pop_front();
                for (int i = 0; i < 12; i++)
                    if (seen[383 - 32 * i -: 32] !== want[383 - 32 * i -: 32])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("field %0d: expected %h got %h", i,
                                     want[383 - 32 * i -: 32], seen[383 - 32 * i -: 32]);
                    end
            end
        end
    end

    task automatic drain();
        while (cells_pending.size() > 0 || in_ch.valid || collisions_due.size() > 0)
            @(posedge clk);
        repeat (lbc_pkg::PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic write_omega(logic [30:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [30:0] omegas[N_PHASES];
        longint one_q;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        omega_q = lbc_pkg::RELAX_RATE_RST;
        in_took = 1'b0;
        out_took = 1'b0;
        gap_left = 0;
        stall_left = 0;
        gap_max = 8;
        stall_max = 8;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        mismatches = 0;
        one_q = 64'sd1 << FB;
        omegas = '{lbc_pkg::RELAX_RATE_RST, 31'd0, 31'h7fffffff, 31'h10000000,
                   31'($urandom)};

        // directed cells: rest state, extremes, bad density, saturated quotient
        cells_pending.push_back('0);
        cells_pending.push_back({9{32'h7fffffff}});
        cells_pending.push_back({9{32'h80000000}});
        cells_pending.push_back({9{32'h00000001}});
        cells_pending.push_back({9{32'hffffffff}});
        cells_pending.push_back({32'(one_q * 4 / 9), {4{32'(one_q / 9)}}, {4{32'(one_q / 36)}}});
        cells_pending.push_back({32'h0, 32'h40000000, 32'h0, 32'hc0000001, {5{32'h0}}});
        cells_pending.push_back({32'h1, 32'h7fffffff, {7{32'h0}}});
        cells_pending.push_back({32'h1, 32'h0, 32'h0, 32'h80000000, {5{32'h0}}});
        cells_pending.push_back({32'h1, 32'h0, 32'h7fffffff, 32'h0, {5{32'h0}}});
        cells_pending.push_back({32'h1, 32'h0, 32'h0, 32'h0, 32'h80000000, {4{32'h0}}});
        cells_pending.push_back({32'h10000000, {4{32'h0}}, 32'h08000000, 32'h0,
                                 32'h0, 32'h0});
        cells_pending.push_back({32'h10000000, {6{32'h0}}, 32'h08000000, 32'h0});
        cells_pending.push_back({32'hf0000000, 32'h01000000, {7{32'h0}}});
        cells_pending.push_back({32'h0, 32'h7fffffff, 32'h7fffffff, {6{32'h0}}});
        cells_pending.push_back({32'h00000010, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                 32'h80000000, {4{32'h0}}});
        cells_pending.push_back({32'h01000000, 32'h00100000, 32'h00200000, 32'h00080000,
                                 32'h00040000, 32'h00010000, 32'h00008000, 32'h00004000,
                                 32'h00020000});
        cells_pending.push_back({9{32'h55555555}});
        cells_pending.push_back({9{32'haaaaaaaa}});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                write_omega(omegas[p]);
            end
            gap_max = (p == 2) ? 0 : 8;
            stall_max = (p == 3) ? 0 : 8;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                cells_pending.push_back(random_cell());
            if (p == 1)
            begin
                // hold the output off while cells keep arriving
                @(posedge clk);
                hold_req = hold_req + 1;
            end
        end
        drain();
        if (mismatches == 0 && collisions_due.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
